// ===== hw/rtl/dcr_pkg.sv =====
// Package for the DC offset remover: constants, widths, payload and control types.
// No dependencies; every module of the block imports it.
package dcr_pkg;

  localparam int MAX_BLOCK = 512;
  localparam int SHIFT     = 14;
  localparam int MEAN_SHR  = 3;

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W  = 17 + $clog2(MAX_BLOCK);
  localparam int MAG_W  = SUM_W - 1;
  localparam int DIV_CW = $clog2(MAG_W + 1);

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_BLOCK - 1);

  typedef struct packed {
    logic signed [31:0] raw_sample;
    logic               last_in_block;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] clean_sample;
    logic               block_end;
  } out_item_t;

  typedef struct packed {
    logic [15:0] shifted;
    logic        closes;
  } q_item_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
    logic             neg;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
    logic             neg;
  } div_rsp_t;

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } back_state_t;

endpackage

// ===== hw/rtl/dcr_front.sv =====
// Front end: accepts raw words, shifts them and marks the item that closes a block.
// Depends on dcr_pkg.
module dcr_front import dcr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output q_item_t  q_item
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             closes;

  assign closes   = in_data.last_in_block || (cnt_r == LAST_CNT);
  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign q_item   = '{shifted: in_data.raw_sample[SHIFT+15:SHIFT], closes: closes};

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_valid && q_ready) begin
      cnt_nxt = closes ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/dcr_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on dcr_pkg.
module dcr_queue import dcr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_valid,
  output logic    wr_ready,
  input  q_item_t wr_item,
  output logic    rd_valid,
  input  logic    rd_ready,
  output q_item_t rd_item
);

  q_item_t     mem_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  fill_r;
  logic        push;
  logic        pop;

  assign wr_ready = (fill_r != 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dcr_div.sv =====
// Restoring divider, one quotient bit per cycle, for the block mean magnitude.
// Depends on dcr_pkg.
module dcr_div import dcr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [CNT_W-1:0]  rem_r;
  logic [MAG_W-1:0]  quo_r;
  logic [CNT_W-1:0]  dvs_r;
  logic              neg_r;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, quo_r[MAG_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});
  assign rsp   = '{done: done_r, quotient: quo_r, neg: neg_r};

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
      neg_r <= req.neg;
    end else if (busy_r) begin
      rem_r <= fits ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
      quo_r <= {quo_r[MAG_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == DIV_CW'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(MAG_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/dcr_back.sv =====
// Back end: offset subtraction, block accumulation, output register, offset update.
// Depends on dcr_pkg and dcr_div.
module dcr_back import dcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  q_item_t   q_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  back_state_t              state_r;
  back_state_t              state_nxt;
  logic signed [31:0]       offset_r;
  logic signed [31:0]       offset_nxt;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_inc;
  logic                     out_valid_r;
  out_item_t                out_data_r;
  logic [15:0]              sample;
  logic                     pop;
  div_req_t                 req;
  div_rsp_t                 rsp;
  logic [MAG_W-1:0]         mean_mag;
  logic signed [32:0]       delta;
  logic signed [32:0]       sum33;

  dcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign sample    = q_item.shifted - offset_r[15:0];
  assign sum_nxt   = sum_r + SUM_W'(signed'(sample));
  assign count_inc = count_r + 1'b1;
  assign mean_mag  = rsp.quotient >> MEAN_SHR;
  assign delta     = rsp.neg ? -$signed({{(33-MAG_W){1'b0}}, mean_mag})
                             :  $signed({{(33-MAG_W){1'b0}}, mean_mag});
  assign sum33     = {offset_r[31], offset_r} + delta;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign q_ready   = (state_r == BK_RUN) && (!out_valid_r || out_ready);
  assign pop       = q_valid && q_ready;

  always_comb begin
    state_nxt    = state_r;
    offset_nxt   = offset_r;
    req.start    = 1'b0;
    req.neg      = sum_nxt[SUM_W-1];
    req.dividend = sum_nxt[SUM_W-1] ? MAG_W'(-sum_nxt) : MAG_W'(sum_nxt);
    req.divisor  = count_inc;
    unique case (state_r)
      BK_RUN: begin
        if (pop && q_item.closes) begin
          req.start = 1'b1;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (rsp.done) begin
          state_nxt = BK_RUN;
          if (sum33[32] != sum33[31]) begin
            offset_nxt = sum33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
          end else begin
            offset_nxt = sum33[31:0];
          end
        end
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= '{clean_sample: sample, block_end: q_item.closes};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      offset_r    <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      offset_r <= offset_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
        sum_r       <= q_item.closes ? '0 : sum_nxt;
        count_r     <= q_item.closes ? '0 : count_inc;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/audio_dc_offset_remover.sv =====
// DC offset remover. Each item passes the two-entry queue and the back-end output register.
// Throughput: one item per cycle inside a block while out_ready is high; after a closing item
// the back end waits for the bit-serial mean divider.
// The two-entry queue keeps taking input while the back end waits, until it is full.
// Reset (rst_n, synchronous): offset, block sum, counts and queue clear.
// Depends on dcr_pkg, dcr_front, dcr_queue, dcr_div, dcr_back.
module audio_dc_offset_remover import dcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic    fq_valid;
  logic    fq_ready;
  q_item_t fq_item;
  logic    qb_valid;
  logic    qb_ready;
  q_item_t qb_item;

  dcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  dcr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  dcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (qb_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tb_audio_dc_offset_remover.sv =====
// Testbench for audio_dc_offset_remover: random and directed words with random stalls
// on both channels, checked against an in-bench DC offset tracker.
// Depends on dcr_pkg and the audio_dc_offset_remover RTL.
`timescale 1ns / 100ps

module tb_audio_dc_offset_remover;
  import dcr_pkg::*;

  localparam int RAW_SHIFT   = 14;
  localparam int MEAN_DIV    = 8;
  localparam int BLOCK_LIMIT = dcr_pkg::MAX_BLOCK;
  localparam int WORD_TARGET = 1515;
  localparam int QUIET_AFTER = 1300;
  localparam int LONG_HOLD   = 300;

  typedef enum int {
    FILL_RANDOM,
    FILL_EXTREME,
    FILL_DC
  } fill_t;

  class dc_offset_tracker;
    int        offset_est;
    longint    sum_acc;
    int        count_acc;
    int        errors;
    out_item_t pending_samples[$];

    function new();
      offset_est = 0;
      sum_acc    = 0;
      count_acc  = 0;
      errors     = 0;
    endfunction

    function void absorb_word(in_item_t w);
      logic signed [31:0] shifted;
      logic signed [15:0] clean;
      longint             diff;
      longint             mean;
      longint             nxt;
      logic               closes;
      out_item_t          exp_item;
      shifted = $signed(w.raw_sample) >>> RAW_SHIFT;
      diff = longint'(shifted) - longint'(offset_est);
      clean = diff[15:0];
      sum_acc += longint'(clean);
      count_acc++;
      closes = w.last_in_block || (count_acc >= BLOCK_LIMIT);
      if (closes) begin
        mean = sum_acc / longint'(count_acc);
        nxt = longint'(offset_est) + mean / MEAN_DIV;
        if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
        if (nxt < -64'sd2147483648) nxt = -64'sd2147483648;
        offset_est = int'(nxt);
        sum_acc = 0;
        count_acc = 0;
      end
      exp_item.clean_sample = clean;
      exp_item.block_end = closes;
      pending_samples.push_back(exp_item);
    endfunction

    function void compare_sample(out_item_t got);
      out_item_t exp_item;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected transfer, actual clean_sample %0d block_end %0b",
                 $time, got.clean_sample, got.block_end);
        errors++;
        return;
      end
      exp_item = pending_samples.pop_front();
      if (got.clean_sample !== exp_item.clean_sample) begin
        $display("%0t: clean_sample mismatch, expected %0d actual %0d",
                 $time, exp_item.clean_sample, got.clean_sample);
        errors++;
      end
      if (got.block_end !== exp_item.block_end) begin
        $display("%0t: block_end mismatch, expected %0b actual %0b",
                 $time, exp_item.block_end, got.block_end);
        errors++;
      end
    endfunction

    function int pending_count();
      return pending_samples.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  dc_offset_tracker tracker;
  int words_sent = 0;
  bit quiet = 1'b0;
  bit tx_idle_on = 1'b1;
  bit hold_request = 1'b0;
  int dc_level = 0;
  int noise_amp = 100;

  audio_dc_offset_remover u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] make_raw(fill_t fill);
    int base;
    case (fill)
      FILL_RANDOM: return $urandom;
      FILL_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: begin
        base = dc_level + int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
        return 32'(base * 16384 + int'($urandom_range(0, 16383)));
      end
    endcase
  endfunction

  task automatic send_word(input logic [31:0] raw, input logic last);
    if (!quiet && tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{raw_sample: raw, last_in_block: last};
    do @(posedge clk); while (!in_ready);
    tracker.absorb_word(in_data);
    words_sent++;
    if (words_sent >= QUIET_AFTER) quiet = 1'b1;
  endtask

  task automatic send_block(input int len, input fill_t fill, input bit mark_last);
    for (int i = 0; i < len; i++) begin
      send_word(make_raw(fill), mark_last && (i == len - 1));
    end
  endtask

  // result side: random stall bursts, one long hold on request
  initial begin
    int hold_cnt;
    int cyc;
    bit rx_idle_on;
    hold_cnt = 0;
    cyc = 0;
    rx_idle_on = 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) tracker.compare_sample(out_data);
      cyc++;
      if (cyc % 64 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cnt = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (!quiet && rx_idle_on && $urandom_range(0, 7) == 0) begin
        hold_cnt = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int blk_idx;
    int len;
    int pick;
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(32'h0000_0000, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_3FFF, 1'b0);
    send_word(32'h0000_4000, 1'b1);
    send_word(32'h1FFF_C000, 1'b0);
    send_word(32'h1FFF_C000, 1'b0);
    send_word(32'h1FFF_C000, 1'b1);
    send_word(32'hE000_0000, 1'b0);
    send_word(32'hE000_0000, 1'b1);
    send_word(32'hAAAA_AAAA, 1'b0);
    send_word(32'h5555_5555, 1'b1);
    send_word(32'hFFFF_C000, 1'b0);
    send_word(32'hFFFF_BFFF, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b1);
    send_word(32'h8000_0000, 1'b1);

    blk_idx = 0;
    while (words_sent < WORD_TARGET) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0) begin
        dc_level = int'($urandom_range(0, 40000)) - 20000;
        noise_amp = $urandom_range(0, 4000);
      end
      if (blk_idx == 5) hold_request = 1'b1;
      pick = $urandom_range(0, 9);
      if (blk_idx == 8) begin
        // closes on the last mark or exactly at the block limit
        send_block($urandom_range(BLOCK_LIMIT - 1, BLOCK_LIMIT), FILL_DC, 1'b1);
      end else if (blk_idx == 30) begin
        // overrun: forced close at the limit, then a short tail
        send_block(BLOCK_LIMIT + $urandom_range(1, 4), FILL_DC, 1'b1);
      end else if (pick == 0) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_word(make_raw(fill_t'($urandom_range(0, 2))), $urandom_range(0, 3) == 0);
        end
      end else if (pick == 1) begin
        send_block($urandom_range(1, 48), FILL_RANDOM, 1'b1);
      end else if (pick == 2) begin
        send_block($urandom_range(1, 16), FILL_EXTREME, 1'b1);
      end else begin
        send_block($urandom_range(1, 48), FILL_DC, 1'b1);
      end
      blk_idx++;
    end
    in_valid <= 1'b0;

    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_count() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
